FILE: rtl/arpf_pkg.sv
// Shared types and constants for the ARP reply frame filter.
package arpf_pkg;

    // Counter and frame sizing
    localparam int CNT_W           = 32;
    localparam int MIN_FRAME_BYTES = 42;
    localparam int POS_W           = 6;
    localparam int FLAG_W          = 8;
    localparam int MAC_W           = 48;
    localparam int IP_W            = 32;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Input operation codes
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_FORGET  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_IP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MAC = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DAD_MODE   = 3'd5;

    // ARP opcodes
    localparam logic [15:0] ARP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_REPLY   = 16'd2;

    // Commands handed from front to back
    typedef enum logic [1:0] {
        CMD_FRAME,
        CMD_FORGET,
        CMD_RESTART
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic             ok;
        logic [1:0]       opcode;
        logic             bcast;
        logic [MAC_W-1:0] sender_mac;
    } t_qentry;

    typedef struct packed {
        logic [MAC_W-1:0] own_mac;
        logic [IP_W-1:0]  own_ip;
        logic [IP_W-1:0]  target_ip;
        logic [MAC_W-1:0] filter_mac;
        logic             filter_en;
        logic             dad;
    } t_cfg;

    typedef struct packed {
        logic             accepted;
        logic [1:0]       arp_opcode;
        logic [MAC_W-1:0] sender_mac;
        logic [MAC_W-1:0] learned_mac;
        logic             learned_valid;
        logic [CNT_W-1:0] received_count;
        logic [CNT_W-1:0] request_count;
        logic [CNT_W-1:0] broadcast_count;
    } t_result;

endpackage

FILE: rtl/arpf_front.sv
// Byte parser: tracks frame position, runs header checks, issues commands.
module arpf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  arpf_pkg::t_cfg            i_cfg,
    input  logic                      i_push,
    input  logic                      i_q_full,
    input  logic [1:0]                i_operation,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_last_byte,
    output logic                      o_q_push,
    output arpf_pkg::t_qentry         o_q_entry
);

    // Flag bit positions
    localparam int FLG_HDR    = 0;
    localparam int FLG_SRC    = 1;
    localparam int FLG_DST    = 2;
    localparam int FLG_BCAST  = 3;
    localparam int FLG_SPA    = 4;
    localparam int FLG_THA    = 5;
    localparam int FLG_TPA    = 6;
    localparam int FLG_SHA_EQ = 7;

    localparam logic [arpf_pkg::POS_W-1:0] POS_LAST = '1;
    localparam logic [arpf_pkg::POS_W-1:0] POS_MIN_LAST =
        arpf_pkg::POS_W'(arpf_pkg::MIN_FRAME_BYTES - 1);

    // Byte i of a MAC, byte 0 most significant
    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = mac[47:40];
            3'd1:    r = mac[39:32];
            3'd2:    r = mac[31:24];
            3'd3:    r = mac[23:16];
            3'd4:    r = mac[15:8];
            3'd5:    r = mac[7:0];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = ip[31:24];
            2'd1:    r = ip[23:16];
            2'd2:    r = ip[15:8];
            default: r = ip[7:0];
        endcase
        return r;
    endfunction

    // Ethertype, hardware type, protocol type, address sizes
    function automatic logic [7:0] hdr_byte(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = 8'h08;
            3'd1:    r = 8'h06;
            3'd2:    r = 8'h00;
            3'd3:    r = 8'h01;
            3'd4:    r = 8'h08;
            3'd5:    r = 8'h00;
            3'd6:    r = 8'h06;
            default: r = 8'h04;
        endcase
        return r;
    endfunction

    // Place a byte into MAC slot i, slot 0 most significant
    function automatic logic [47:0] put_mac_byte(input logic [47:0] mac,
                                                 input logic [2:0]  i,
                                                 input logic [7:0]  b);
        logic [47:0] r;
        r = mac;
        case (i)
            3'd0:    r[47:40] = r[47:40] | b;
            3'd1:    r[39:32] = r[39:32] | b;
            3'd2:    r[31:24] = r[31:24] | b;
            3'd3:    r[23:16] = r[23:16] | b;
            3'd4:    r[15:8]  = r[15:8]  | b;
            3'd5:    r[7:0]   = r[7:0]   | b;
            default: r = mac;
        endcase
        return r;
    endfunction

    logic [arpf_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [arpf_pkg::FLAG_W-1:0] r_flags, n_flags;
    logic [15:0]                 r_opcode, n_opcode;
    logic [arpf_pkg::MAC_W-1:0]  r_smac, n_smac;

    logic                        accept;
    logic [arpf_pkg::FLAG_W-1:0] clr;
    logic [arpf_pkg::POS_W-1:0]  rel;
    logic                        ip_has_zero;
    logic                        frame_ok;

    assign accept = i_push && !i_q_full;

    // Per-byte checks against the configuration
    always_comb begin
        clr      = '0;
        rel      = '0;
        n_opcode = r_opcode;
        n_smac   = r_smac;
        if (r_pos < 6'd6) begin
            rel = r_pos;
            if (i_data_byte != mac_byte(i_cfg.own_mac, rel[2:0])) clr[FLG_DST] = 1'b1;
            if (i_data_byte != 8'hFF) clr[FLG_BCAST] = 1'b1;
        end else if (r_pos < 6'd12) begin
            rel = r_pos - 6'd6;
            if (i_data_byte != mac_byte(i_cfg.filter_mac, rel[2:0])) clr[FLG_SRC] = 1'b1;
        end else if (r_pos < 6'd20) begin
            rel = r_pos - 6'd12;
            if (i_data_byte != hdr_byte(rel[2:0])) clr[FLG_HDR] = 1'b1;
        end else if (r_pos < 6'd22) begin
            n_opcode = {r_opcode[7:0], i_data_byte};
        end else if (r_pos < 6'd28) begin
            rel    = r_pos - 6'd22;
            n_smac = put_mac_byte(r_smac, rel[2:0], i_data_byte);
            if (i_data_byte != mac_byte(i_cfg.own_mac, rel[2:0])) clr[FLG_SHA_EQ] = 1'b1;
        end else if (r_pos < 6'd32) begin
            rel = r_pos - 6'd28;
            if (i_data_byte != ip_byte(i_cfg.target_ip, rel[1:0])) clr[FLG_SPA] = 1'b1;
        end else if (r_pos < 6'd38) begin
            rel = r_pos - 6'd32;
            if (i_data_byte != mac_byte(i_cfg.own_mac, rel[2:0])) clr[FLG_THA] = 1'b1;
        end else if (r_pos < 6'd42) begin
            rel = r_pos - 6'd38;
            if (i_data_byte != ip_byte(i_cfg.own_ip, rel[1:0])) clr[FLG_TPA] = 1'b1;
        end
        n_flags = r_flags & ~clr;
        n_pos   = (r_pos == POS_LAST) ? r_pos : r_pos + 6'd1;
    end

    // Verdict on the final byte
    always_comb begin
        ip_has_zero = (i_cfg.own_ip[31:24] == 8'h00) || (i_cfg.own_ip[23:16] == 8'h00) ||
                      (i_cfg.own_ip[15:8] == 8'h00)  || (i_cfg.own_ip[7:0] == 8'h00);
        frame_ok = (r_pos >= POS_MIN_LAST) && n_flags[FLG_HDR] &&
                   (!i_cfg.filter_en || n_flags[FLG_SRC]) &&
                   ((n_opcode == arpf_pkg::ARP_REQUEST) || (n_opcode == arpf_pkg::ARP_REPLY)) &&
                   n_flags[FLG_SPA];
        if (i_cfg.dad) begin
            frame_ok = frame_ok && !n_flags[FLG_SHA_EQ] && (ip_has_zero || n_flags[FLG_TPA]);
        end else begin
            frame_ok = frame_ok && n_flags[FLG_DST] && n_flags[FLG_THA] && n_flags[FLG_TPA];
        end
    end

    // Command issue toward the back part
    always_comb begin
        o_q_push             = 1'b0;
        o_q_entry.cmd        = arpf_pkg::CMD_FRAME;
        o_q_entry.ok         = frame_ok;
        o_q_entry.opcode     = n_opcode[1:0];
        o_q_entry.bcast      = n_flags[FLG_BCAST];
        o_q_entry.sender_mac = n_smac;
        case (i_operation)
            arpf_pkg::OP_BYTE: begin
                o_q_push = accept && i_last_byte;
            end
            arpf_pkg::OP_FORGET: begin
                o_q_push      = accept;
                o_q_entry.cmd = arpf_pkg::CMD_FORGET;
            end
            arpf_pkg::OP_RESTART: begin
                o_q_push      = accept;
                o_q_entry.cmd = arpf_pkg::CMD_RESTART;
            end
            default: begin
                o_q_push = 1'b0;
            end
        endcase
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_flags  <= '1;
            r_opcode <= '0;
            r_smac   <= '0;
        end else if (accept) begin
            case (i_operation)
                arpf_pkg::OP_BYTE: begin
                    if (i_last_byte) begin
                        r_pos    <= '0;
                        r_flags  <= '1;
                        r_opcode <= '0;
                        r_smac   <= '0;
                    end else begin
                        r_pos    <= n_pos;
                        r_flags  <= n_flags;
                        r_opcode <= n_opcode;
                        r_smac   <= n_smac;
                    end
                end
                arpf_pkg::OP_RESTART: begin
                    r_pos    <= '0;
                    r_flags  <= '1;
                    r_opcode <= '0;
                    r_smac   <= '0;
                end
                default: begin
                    r_pos <= r_pos;
                end
            endcase
        end
    end

endmodule

FILE: rtl/arpf_queue.sv
// Short command queue between the parser and the result stage.
module arpf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  arpf_pkg::t_qentry i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output arpf_pkg::t_qentry o_head
);

    arpf_pkg::t_qentry              r_mem [arpf_pkg::QUEUE_DEPTH];
    logic [arpf_pkg::QPTR_W-1:0]    r_wptr;
    logic [arpf_pkg::QPTR_W-1:0]    r_rptr;
    logic [arpf_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (r_count == arpf_pkg::QCNT_W'(arpf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    // Pointers and occupancy; push is only given when not full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + arpf_pkg::QPTR_W'(1);
            if (i_pop)  r_rptr <= r_rptr + arpf_pkg::QPTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + arpf_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - arpf_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/arpf_back.sv
// Result stage: learned MAC, counters and the output register.
module arpf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  arpf_pkg::t_qentry i_q_head,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output arpf_pkg::t_result o_result
);

    logic [arpf_pkg::MAC_W-1:0] r_learned_mac, n_learned_mac;
    logic                       r_learned_valid, n_learned_valid;
    logic [arpf_pkg::CNT_W-1:0] r_rx_cnt, n_rx_cnt;
    logic [arpf_pkg::CNT_W-1:0] r_req_cnt, n_req_cnt;
    logic [arpf_pkg::CNT_W-1:0] r_bc_cnt, n_bc_cnt;
    logic                       r_out_valid;
    arpf_pkg::t_result          r_out;

    logic slot_free;
    logic is_frame;

    assign slot_free = !r_out_valid || i_pop;
    assign is_frame  = (i_q_head.cmd == arpf_pkg::CMD_FRAME);
    assign o_q_pop   = !i_q_empty && (!is_frame || slot_free);
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    // Next learned state and counters for the head command
    always_comb begin
        n_learned_mac   = r_learned_mac;
        n_learned_valid = r_learned_valid;
        n_rx_cnt        = r_rx_cnt;
        n_req_cnt       = r_req_cnt;
        n_bc_cnt        = r_bc_cnt;
        case (i_q_head.cmd)
            arpf_pkg::CMD_FRAME: begin
                if (i_q_head.ok) begin
                    if (!r_learned_valid) begin
                        n_learned_mac   = i_q_head.sender_mac;
                        n_learned_valid = 1'b1;
                    end
                    n_rx_cnt = r_rx_cnt + arpf_pkg::CNT_W'(1);
                    if (i_q_head.opcode == arpf_pkg::ARP_REQUEST[1:0]) begin
                        n_req_cnt = r_req_cnt + arpf_pkg::CNT_W'(1);
                    end
                    if (i_q_head.bcast) begin
                        n_bc_cnt = r_bc_cnt + arpf_pkg::CNT_W'(1);
                    end
                end
            end
            arpf_pkg::CMD_FORGET: begin
                n_learned_mac   = '0;
                n_learned_valid = 1'b0;
            end
            arpf_pkg::CMD_RESTART: begin
                n_learned_mac   = '0;
                n_learned_valid = 1'b0;
                n_rx_cnt        = '0;
                n_req_cnt       = '0;
                n_bc_cnt        = '0;
            end
            default: begin
                n_learned_mac = r_learned_mac;
            end
        endcase
    end

    // Persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learned_mac   <= '0;
            r_learned_valid <= 1'b0;
            r_rx_cnt        <= '0;
            r_req_cnt       <= '0;
            r_bc_cnt        <= '0;
        end else if (o_q_pop) begin
            r_learned_mac   <= n_learned_mac;
            r_learned_valid <= n_learned_valid;
            r_rx_cnt        <= n_rx_cnt;
            r_req_cnt       <= n_req_cnt;
            r_bc_cnt        <= n_bc_cnt;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop && is_frame) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload snapshot
    always_ff @(posedge i_clk) begin
        if (o_q_pop && is_frame) begin
            r_out.accepted        <= i_q_head.ok;
            r_out.arp_opcode      <= i_q_head.ok ? i_q_head.opcode : 2'd0;
            r_out.sender_mac      <= i_q_head.sender_mac;
            r_out.learned_mac     <= n_learned_mac;
            r_out.learned_valid   <= n_learned_valid;
            r_out.received_count  <= n_rx_cnt;
            r_out.request_count   <= n_req_cnt;
            r_out.broadcast_count <= n_bc_cnt;
        end
    end

endmodule

FILE: rtl/arp_reply_frame_filter_unit.sv
// ARP reply frame filter top level: configuration registers, parser, queue, result stage.
// Throughput: one byte or command per cycle; a result can leave every cycle.
// A final byte's command is written into the command queue when the byte is taken; the
// output register is then loaded from the queue head once the output slot is free.
// Input stalls only when the 4-entry command queue is full behind a stalled output.
// Synchronous active-low reset clears configuration, frame state, counters and queues.
module arp_reply_frame_filter_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         i_operation,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_last_byte,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_accepted,
    output logic [1:0]                         o_arp_opcode,
    output logic [arpf_pkg::MAC_W-1:0]         o_sender_mac,
    output logic [arpf_pkg::MAC_W-1:0]         o_learned_mac,
    output logic                               o_learned_valid,
    output logic [arpf_pkg::CNT_W-1:0]         o_received_count,
    output logic [arpf_pkg::CNT_W-1:0]         o_request_count,
    output logic [arpf_pkg::CNT_W-1:0]         o_broadcast_count,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [arpf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [arpf_pkg::MAC_W-1:0]         i_cfg_data
);

    arpf_pkg::t_cfg    r_cfg;
    arpf_pkg::t_qentry q_entry;
    arpf_pkg::t_qentry q_head;
    arpf_pkg::t_result result;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;

    // Configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                arpf_pkg::CFG_OWN_MAC:    r_cfg.own_mac    <= i_cfg_data;
                arpf_pkg::CFG_OWN_IP:     r_cfg.own_ip     <= i_cfg_data[arpf_pkg::IP_W-1:0];
                arpf_pkg::CFG_TARGET_IP:  r_cfg.target_ip  <= i_cfg_data[arpf_pkg::IP_W-1:0];
                arpf_pkg::CFG_FILTER_MAC: r_cfg.filter_mac <= i_cfg_data;
                arpf_pkg::CFG_FILTER_EN:  r_cfg.filter_en  <= i_cfg_data[0];
                arpf_pkg::CFG_DAD_MODE:   r_cfg.dad        <= i_cfg_data[0];
                default:                  r_cfg            <= r_cfg;
            endcase
        end
    end

    arpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_q_full    (q_full),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_q_push    (q_push),
        .o_q_entry   (q_entry)
    );

    arpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    arpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    // Result ports
    assign o_accepted        = result.accepted;
    assign o_arp_opcode      = result.arp_opcode;
    assign o_sender_mac      = result.sender_mac;
    assign o_learned_mac     = result.learned_mac;
    assign o_learned_valid   = result.learned_valid;
    assign o_received_count  = result.received_count;
    assign o_request_count   = result.request_count;
    assign o_broadcast_count = result.broadcast_count;

endmodule

FILE: rtl/arpf_checker.sv
// Port-level checks for the ARP reply frame filter, bound to the top level.
module arpf_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    input  logic                           full,
    input  logic [1:0]                     i_operation,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    input  logic                           empty,
    input  logic                           pop,
    input  logic                           o_accepted,
    input  logic [1:0]                     o_arp_opcode,
    input  logic [arpf_pkg::MAC_W-1:0]     o_sender_mac,
    input  logic [arpf_pkg::MAC_W-1:0]     o_learned_mac,
    input  logic                           o_learned_valid,
    input  logic [arpf_pkg::CNT_W-1:0]     o_received_count,
    input  logic [arpf_pkg::CNT_W-1:0]     o_request_count,
    input  logic [arpf_pkg::CNT_W-1:0]     o_broadcast_count,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [arpf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [arpf_pkg::MAC_W-1:0]     i_cfg_data
);

    // Reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting after reset");

    // Rejected frames report opcode zero
    a_reject_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_accepted) |-> (o_arp_opcode == 2'd0))
        else $error("rejected frame with nonzero opcode");

    // Accepted frames carry a request or reply opcode and a nonzero count
    a_accept_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_accepted) |->
            ((o_arp_opcode == arpf_pkg::ARP_REQUEST[1:0] ||
              o_arp_opcode == arpf_pkg::ARP_REPLY[1:0]) && o_learned_valid &&
             (o_received_count != '0)))
        else $error("accepted frame with inconsistent fields");

    // A waiting transaction holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_sender_mac) && $stable(o_received_count)))
        else $error("waiting result changed before pop");

endmodule

bind arp_reply_frame_filter_unit arpf_checker u_arpf_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for the ARP reply frame filter unit.
`timescale 1ns / 1ps

module tb_top;
    import arpf_pkg::*;

    // Code the block ignores, and the fixed ARP header bytes 12..19
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [63:0] ARP_HDR   = 64'h0806_0001_0800_0604;

    localparam int  SETTLE_CYCLES = 12;     // lets the command queue and output register drain, with margin
    localparam int  HOLD_CYCLES   = 400;
    localparam int  RANDOM_ITEMS  = 1000;
    localparam int  PHASE_ITEMS   = 250;
    localparam longint TIMEOUT_NS = 10_000_000;

    // DUT ports
    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    logic [1:0]           i_operation = OP_BYTE;
    logic [7:0]           i_data_byte = 8'h00;
    logic                 i_last_byte = 1'b0;
    logic                 empty;
    logic                 pop         = 1'b0;
    logic                 o_accepted;
    logic [1:0]           o_arp_opcode;
    logic [MAC_W-1:0]     o_sender_mac;
    logic [MAC_W-1:0]     o_learned_mac;
    logic                 o_learned_valid;
    logic [CNT_W-1:0]     o_received_count;
    logic [CNT_W-1:0]     o_request_count;
    logic [CNT_W-1:0]     o_broadcast_count;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_OWN_MAC;
    logic [MAC_W-1:0]     i_cfg_data  = '0;

    arp_reply_frame_filter_unit u_top (.*);

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Filter state as the block should hold it
    t_cfg             cfg_now = '0;
    int               frm_pos = 0;
    logic             hdr_ok, src_ok, dst_ok, bcast_ok, spa_ok, tha_ok, tpa_ok, sha_same;
    logic [15:0]      opc_word = '0;
    logic [MAC_W-1:0] sha_cap = '0;
    logic [MAC_W-1:0] learnt_mac = '0;
    logic             learnt_valid = 1'b0;
    logic [CNT_W-1:0] cnt_rx = '0, cnt_req = '0, cnt_bcast = '0;

    t_result pending_verdicts[$];

    // Bookkeeping
    int   errors        = 0;
    int   items_sent    = 0;
    bit   push_hi       = 1'b0;
    bit   steady        = 1'b0;
    int   hold_ask      = 0;
    logic [7:0] frame_img [0:41];

    initial begin
        hdr_ok = 1'b1; src_ok = 1'b1; dst_ok = 1'b1; bcast_ok = 1'b1;
        spa_ok = 1'b1; tha_ok = 1'b1; tpa_ok = 1'b1; sha_same = 1'b1;
    end

    // Mostly no gap, sometimes a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [MAC_W-1:0] pick_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: w = '0;
            1: w = '1;
            default: ;
        endcase
        return w[MAC_W-1:0];
    endfunction

    function automatic logic [IP_W-1:0] pick_ip();
        logic [IP_W-1:0] w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0: w = '0;
            1: w = '1;
            2: w[8*$urandom_range(0, 3) +: 8] = 8'h00;
            default: ;
        endcase
        return w;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < 100)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, field, got, want);
        errors++;
    endtask

    task automatic clear_frame();
        frm_pos  = 0;
        hdr_ok   = 1'b1; src_ok = 1'b1; dst_ok = 1'b1; bcast_ok = 1'b1;
        spa_ok   = 1'b1; tha_ok = 1'b1; tpa_ok = 1'b1; sha_same = 1'b1;
        opc_word = '0;
        sha_cap  = '0;
    endtask

    // Advance the filter by one accepted item; a marked final byte yields a verdict
    task automatic predict_arp_result(input logic [1:0] op, input logic [7:0] b,
                                      input logic last);
        int      p;
        logic    ok;
        logic    ip_zero;
        t_result r;
        case (op)
            OP_FORGET: begin
                learnt_valid = 1'b0;
                learnt_mac   = '0;
            end
            OP_RESTART: begin
                learnt_valid = 1'b0;
                learnt_mac   = '0;
                cnt_rx       = '0;
                cnt_req      = '0;
                cnt_bcast    = '0;
                clear_frame();
            end
            OP_BYTE: begin
                p = frm_pos;
                // per-field byte checks against the registers of this cycle
                if (p < 6) begin
                    if (b != cfg_now.own_mac[47-8*p -: 8]) dst_ok = 1'b0;
                    if (b != 8'hFF) bcast_ok = 1'b0;
                end else if (p < 12) begin
                    if (b != cfg_now.filter_mac[47-8*(p-6) -: 8]) src_ok = 1'b0;
                end else if (p < 20) begin
                    if (b != ARP_HDR[63-8*(p-12) -: 8]) hdr_ok = 1'b0;
                end else if (p < 22) begin
                    opc_word = {opc_word[7:0], b};
                end else if (p < 28) begin
                    sha_cap[8*(27-p) +: 8] = b;
                    if (b != cfg_now.own_mac[47-8*(p-22) -: 8]) sha_same = 1'b0;
                end else if (p < 32) begin
                    if (b != cfg_now.target_ip[31-8*(p-28) -: 8]) spa_ok = 1'b0;
                end else if (p < 38) begin
                    if (b != cfg_now.own_mac[47-8*(p-32) -: 8]) tha_ok = 1'b0;
                end else if (p < 42) begin
                    if (b != cfg_now.own_ip[31-8*(p-38) -: 8]) tpa_ok = 1'b0;
                end
                if (p < 63)
                    frm_pos = p + 1;

                if (last) begin
                    ip_zero = (cfg_now.own_ip[31:24] == 8'h00) ||
                              (cfg_now.own_ip[23:16] == 8'h00) ||
                              (cfg_now.own_ip[15:8]  == 8'h00) ||
                              (cfg_now.own_ip[7:0]   == 8'h00);
                    ok = (p + 1 >= MIN_FRAME_BYTES) && hdr_ok &&
                         (!cfg_now.filter_en || src_ok) &&
                         (opc_word == ARP_REQUEST || opc_word == ARP_REPLY) && spa_ok;
                    if (cfg_now.dad)
                        ok = ok && !sha_same && (ip_zero || tpa_ok);
                    else
                        ok = ok && dst_ok && tha_ok && tpa_ok;

                    if (ok) begin
                        if (!learnt_valid) begin
                            learnt_mac   = sha_cap;
                            learnt_valid = 1'b1;
                        end
                        cnt_rx++;
                        if (opc_word == ARP_REQUEST) cnt_req++;
                        if (bcast_ok) cnt_bcast++;
                    end

                    r.accepted        = ok;
                    r.arp_opcode      = ok ? opc_word[1:0] : 2'd0;
                    r.sender_mac      = sha_cap;
                    r.learned_mac     = learnt_mac;
                    r.learned_valid   = learnt_valid;
                    r.received_count  = cnt_rx;
                    r.request_count   = cnt_req;
                    r.broadcast_count = cnt_bcast;
                    pending_verdicts.push_back(r);
                    clear_frame();
                end
            end
            default: ;
        endcase
    endtask

    // Offer one item and hold it until taken; push stays high unless a gap follows
    task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic last);
        int gap;
        push        <= 1'b1;
        push_hi     = 1'b1;
        i_operation <= op;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_arp_result(op, b, last);
        if (op != OP_UNUSED)
            items_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            push    <= 1'b0;
            push_hi = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send len bytes of the frame image (random past byte 41), with an optional
    // command slipped in ahead of byte cmd_at
    task automatic send_frame(input int len, input int cmd_at, input logic [1:0] cmd_op);
        int i;
        for (i = 0; i < len; i++) begin
            if (i == cmd_at)
                send_item(cmd_op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            send_item(OP_BYTE, (i < 42) ? frame_img[i] : 8'($urandom_range(0, 255)),
                      i == len - 1);
        end
    endtask

    task automatic put_mac(input int at, input logic [MAC_W-1:0] m);
        int k;
        for (k = 0; k < 6; k++)
            frame_img[at+k] = m[47-8*k -: 8];
    endtask

    task automatic put_ip(input int at, input logic [IP_W-1:0] a);
        int k;
        for (k = 0; k < 4; k++)
            frame_img[at+k] = a[31-8*k -: 8];
    endtask

    // Frame image that passes every check under the current registers
    task automatic build_reply();
        logic [63:0] w;
        int k;
        w = {$urandom, $urandom};
        put_mac(0, cfg_now.dad ? {MAC_W{1'b1}} : cfg_now.own_mac);
        put_mac(6, cfg_now.filter_mac);
        for (k = 0; k < 8; k++)
            frame_img[12+k] = ARP_HDR[63-8*k -: 8];
        frame_img[20] = 8'h00;
        frame_img[21] = ($urandom_range(0, 1) != 0) ? ARP_REQUEST[7:0] : ARP_REPLY[7:0];
        put_mac(22, w[MAC_W-1:0]);
        put_ip(28, cfg_now.target_ip);
        put_mac(32, cfg_now.dad ? {MAC_W{1'b0}} : cfg_now.own_mac);
        put_ip(38, cfg_now.own_ip);
    endtask

    // One register write transaction; valid is left high for a following write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Write all registers; only called while the block is idle
    task automatic load_config(input t_cfg c);
        cfg_write(CFG_OWN_MAC, c.own_mac);
        cfg_write(CFG_OWN_IP, MAC_W'(c.own_ip));
        cfg_write(CFG_TARGET_IP, MAC_W'(c.target_ip));
        cfg_write(CFG_FILTER_MAC, c.filter_mac);
        cfg_write(CFG_FILTER_EN, MAC_W'(c.filter_en));
        cfg_write(CFG_DAD_MODE, MAC_W'(c.dad));
        i_cfg_valid <= 1'b0;
        cfg_now = c;
    endtask

    // Stop offering, wait for every verdict, then let trailing commands settle
    task automatic wait_drained();
        if (push_hi) begin
            push    <= 1'b0;
            push_hi = 1'b0;
        end
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_verdict();
        t_result want;
        if (pending_verdicts.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(o_accepted), '0);
        end else begin
            want = pending_verdicts.pop_front();
            if (o_accepted !== want.accepted)
                report_mismatch("accepted", 64'(o_accepted), 64'(want.accepted));
            if (o_arp_opcode !== want.arp_opcode)
                report_mismatch("arp_opcode", 64'(o_arp_opcode), 64'(want.arp_opcode));
            if (o_sender_mac !== want.sender_mac)
                report_mismatch("sender_mac", 64'(o_sender_mac), 64'(want.sender_mac));
            if (o_learned_mac !== want.learned_mac)
                report_mismatch("learned_mac", 64'(o_learned_mac), 64'(want.learned_mac));
            if (o_learned_valid !== want.learned_valid)
                report_mismatch("learned_valid", 64'(o_learned_valid),
                                64'(want.learned_valid));
            if (o_received_count !== want.received_count)
                report_mismatch("received_count", 64'(o_received_count),
                                64'(want.received_count));
            if (o_request_count !== want.request_count)
                report_mismatch("request_count", 64'(o_request_count),
                                64'(want.request_count));
            if (o_broadcast_count !== want.broadcast_count)
                report_mismatch("broadcast_count", 64'(o_broadcast_count),
                                64'(want.broadcast_count));
        end
    endtask

    // Result side: check each transaction, then pick pop for the next cycle
    int hold_left  = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                check_verdict();
            if (hold_ask != 0) begin
                hold_left = hold_ask;
                hold_ask  = 0;
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Extremes of the fields, both opcodes and each corner of the rules
    task automatic test_directed_cases();
        t_cfg c;
        c.own_mac    = 48'h02_11_22_33_44_55;
        c.own_ip     = 32'hC0A8_0001;
        c.target_ip  = 32'hC0A8_0002;
        c.filter_mac = 48'h02_AA_BB_CC_DD_EE;
        c.filter_en  = 1'b1;
        c.dad        = 1'b0;
        load_config(c);

        // request at minimum length, reply padded
        build_reply(); frame_img[21] = ARP_REQUEST[7:0];
        send_frame(MIN_FRAME_BYTES, -1, OP_BYTE);
        build_reply(); frame_img[21] = ARP_REPLY[7:0];
        send_frame(60, -1, OP_BYTE);
        // opcode zero, and opcode with its high byte set
        build_reply(); frame_img[21] = 8'h00;
        send_frame(MIN_FRAME_BYTES, -1, OP_BYTE);
        build_reply(); frame_img[20] = 8'h01;
        send_frame(MIN_FRAME_BYTES, -1, OP_BYTE);
        // one byte short, and a frame of a single byte
        build_reply(); send_frame(MIN_FRAME_BYTES - 1, -1, OP_BYTE);
        build_reply(); send_frame(1, -1, OP_BYTE);
        // source MAC off by one bit with the filter on
        build_reply(); frame_img[11] ^= 8'h80;
        send_frame(MIN_FRAME_BYTES, -1, OP_BYTE);
        // address size byte wrong
        build_reply(); frame_img[19] = 8'h06;
        send_frame(MIN_FRAME_BYTES, -1, OP_BYTE);
        // long frame runs the position into saturation
        build_reply(); send_frame(100, -1, OP_BYTE);
        // forget mid-frame: frame survives and its sender is learned again
        build_reply(); send_frame(MIN_FRAME_BYTES, 25, OP_FORGET);
        // restart mid-frame: leading bytes dropped, tail is a short frame
        build_reply(); send_frame(MIN_FRAME_BYTES, 10, OP_RESTART);
        // unused code inside a frame changes nothing
        build_reply(); send_frame(MIN_FRAME_BYTES, 30, OP_UNUSED);
        wait_drained();

        // duplicate detection, own IP has a zero byte: target IP not checked
        c.dad       = 1'b1;
        c.filter_en = 1'b0;
        load_config(c);
        build_reply(); frame_img[41] ^= 8'h01;
        send_frame(MIN_FRAME_BYTES, -1, OP_BYTE);
        build_reply(); put_mac(22, c.own_mac);
        send_frame(MIN_FRAME_BYTES, -1, OP_BYTE);
        wait_drained();

        // duplicate detection, own IP without zero byte: target IP must match
        c.own_ip = 32'hC0A8_0101;
        load_config(c);
        build_reply(); frame_img[41] ^= 8'h01;
        send_frame(MIN_FRAME_BYTES, -1, OP_BYTE);
        build_reply(); send_frame(MIN_FRAME_BYTES, -1, OP_BYTE);
        wait_drained();

        // all-ones registers: destination is broadcast in normal mode too
        c.own_mac    = '1;
        c.own_ip     = '1;
        c.target_ip  = '1;
        c.filter_mac = '1;
        c.filter_en  = 1'b1;
        c.dad        = 1'b0;
        load_config(c);
        build_reply(); send_frame(MIN_FRAME_BYTES, -1, OP_BYTE);
        wait_drained();

        c = '0;
        load_config(c);
        build_reply(); send_frame(MIN_FRAME_BYTES, -1, OP_BYTE);
        wait_drained();
    endtask

    // Mostly well-formed frames with random damage, over several register settings
    task automatic test_random_traffic();
        t_cfg       c;
        int         ph;
        int         start_items;
        int         phase_start;
        int         len;
        int         cmd_at;
        int         r;
        int         k;
        int         bitpos;
        logic [1:0] cmd_op;
        ph             = 0;
        start_items    = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            c.own_mac    = pick_mac();
            c.own_ip     = pick_ip();
            c.target_ip  = pick_ip();
            c.filter_mac = pick_mac();
            c.filter_en  = (ph < 4) ? ph[1] : 1'($urandom_range(0, 1));
            c.dad        = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
            steady       = (ph % 5 == 3);
            load_config(c);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                build_reply();
                // damage some frames
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    k      = $urandom_range(0, 41);
                    bitpos = $urandom_range(0, 7);
                    frame_img[k][bitpos] = ~frame_img[k][bitpos];
                end else if (r < 40) begin
                    frame_img[$urandom_range(0, 41)] = 8'($urandom_range(0, 255));
                end else if (r < 45) begin
                    for (k = 0; k < 42; k++)
                        frame_img[k] = 8'($urandom_range(0, 255));
                end
                // mostly near the minimum, some short, a few long
                r = $urandom_range(0, 99);
                if (r < 8)
                    len = $urandom_range(1, MIN_FRAME_BYTES - 1);
                else if (r < 13)
                    len = $urandom_range(64, 100);
                else
                    len = $urandom_range(MIN_FRAME_BYTES, 48);
                cmd_at = -1;
                cmd_op = OP_FORGET;
                if ($urandom_range(0, 99) < 6) begin
                    cmd_at = $urandom_range(0, len - 1);
                    r      = $urandom_range(0, 99);
                    cmd_op = (r < 50) ? OP_FORGET : (r < 85) ? OP_UNUSED : OP_RESTART;
                end
                send_frame(len, cmd_at, cmd_op);
            end
            wait_drained();
            ph++;
        end
        steady = 1'b0;
    endtask

    // Hold results back until the queue fills and input stalls, then drain fully
    task automatic test_output_backpressure();
        int i;
        steady   = 1'b1;
        hold_ask = HOLD_CYCLES;
        repeat (2) @(posedge i_clk);
        for (i = 0; i < 12; i++) begin
            build_reply();
            send_frame((i % 2 != 0) ? 1 : MIN_FRAME_BYTES, -1, OP_BYTE);
        end
        steady = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();
        wait_drained();
        if (errors == 0)
            $display("** arp_reply_frame_filter_unit: PASSED **");
        else
            $display("** arp_reply_frame_filter_unit: FAILED **");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("** arp_reply_frame_filter_unit: FAILED **");
        $finish;
    end

endmodule

FILE: arp_reply_frame_filter_unit.f
rtl/arpf_pkg.sv
rtl/arpf_front.sv
rtl/arpf_queue.sv
rtl/arpf_back.sv
rtl/arp_reply_frame_filter_unit.sv
rtl/arpf_checker.sv
dv/tb_top.sv
